>>> hw/rtl/srt_pkg.sv
// Shared types and constants for the sorted region table.
// Holds the beat structs, action and status codes and space constants.
// No dependencies.
package srt_pkg;

    // Size of the unit space and default table depth
    localparam int SPACE_UNITS     = 256;
    localparam int MAX_ENTRIES_DEF = 16;

    // Width of the sums that can pass the end of the space
    localparam int SUM_W = 10;
    localparam logic [SUM_W-1:0] SPACE_END = SUM_W'(SPACE_UNITS);

    // Action codes
    localparam logic [2:0] ACT_ADD     = 3'd0;
    localparam logic [2:0] ACT_RESIZE  = 3'd1;
    localparam logic [2:0] ACT_ERASE   = 3'd2;
    localparam logic [2:0] ACT_GAPS    = 3'd3;
    localparam logic [2:0] ACT_ENTRIES = 3'd4;

    // Status codes
    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_REJECT = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_ROW    = 3'd3;
    localparam logic [2:0] ST_NOROWS = 3'd4;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] entry_slot;
        logic [7:0] region_first;
        logic [8:0] region_units;
    } srt_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] row_slot;
        logic [7:0] row_first;
        logic [7:0] row_final;
        logic [8:0] row_units;
        logic       last_row;
    } srt_out_t;

    // One table entry as stored in memory
    typedef struct packed {
        logic [7:0] first;
        logic [8:0] units;
    } srt_entry_t;

endpackage

>>> hw/rtl/srt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/sorted_region_table.sv
// Sorted region table: one command beat in, one or more result beats out.
// Depends on srt_pkg and srt_ram.
//
// The block keeps up to MAX_ENTRIES non-overlapping regions sorted by first
// unit in one RAM with a registered read. It takes one command at a time.
// Add and resize first scan the table at one entry a cycle, then move
// entries one at a time through the RAM, each read in S_MRD and written in
// S_MWR, then write the new entry. Erase moves the later entries down the
// same way and drops the count. Listing reads each entry and emits it as a
// row, waiting whenever the result side is not free. Results leave through
// an output register, so the next command is taken while the last result
// still waits.
module sorted_region_table
    import srt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  srt_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output srt_out_t m_data
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = (CW > 4) ? CW : 4;
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_MRD  = 4'd3;
    localparam logic [3:0] S_MWR  = 4'd4;
    localparam logic [3:0] S_FIN  = 4'd5;
    localparam logic [3:0] S_RESP = 4'd6;
    localparam logic [3:0] S_LRD  = 4'd7;
    localparam logic [3:0] S_LOUT = 4'd8;
    localparam logic [3:0] S_GRD  = 4'd9;
    localparam logic [3:0] S_GOUT = 4'd10;
    localparam logic [3:0] S_GEND = 4'd11;

    logic [3:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    srt_in_t          cmd_reg, cmd_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    rem_reg, rem_next;
    logic             up_reg, up_next;
    logic             fin_reg, fin_next;
    logic [2:0]       res_reg, res_next;
    logic             rv_reg, rv_next;
    logic [AW-1:0]    ra_reg, ra_next;
    logic             cov_reg, cov_next;
    logic             found_reg, found_next;
    logic [7:0]       nxt_reg, nxt_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [SUM_W-1:0] gpos_reg, gpos_next;
    logic             pend_reg, pend_next;
    srt_out_t         prow_reg, prow_next;
    logic             out_valid_reg, out_valid_next;
    srt_out_t         out_reg, out_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    srt_entry_t       wr_data;
    logic [AW-1:0]    rd_addr;
    srt_entry_t       rd_data;

    logic             out_free;
    logic [SUM_W-1:0] ent_end;
    logic [SUM_W-1:0] room;
    logic             bad;
    logic             skip_hit;
    srt_out_t         none_row;
    srt_out_t         gap_row;
    srt_out_t         tail_row;
    srt_out_t         ent_row;

    srt_ram #(
        .WIDTH($bits(srt_entry_t)),
        .DEPTH(MAX_ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign out_free = !out_valid_reg || m_ready;

    // Entry end, acceptance check and candidate result rows
    always_comb begin
        ent_end  = SUM_W'(rd_data.first) + SUM_W'(rd_data.units);
        skip_hit = (cmd_reg.action == ACT_RESIZE) && (SW'(ra_reg) == SW'(cmd_reg.entry_slot));
        room     = found_reg ? (SUM_W'(nxt_reg) - SUM_W'(cmd_reg.region_first))
                             : (SPACE_END - SUM_W'(cmd_reg.region_first));
        bad      = (cmd_reg.region_units == 9'd0)
                || (SUM_W'(cmd_reg.region_first) >= SPACE_END)
                || cov_reg
                || (SUM_W'(cmd_reg.region_units) > room);

        none_row = '0;
        none_row.last_row = 1'b1;

        ent_row           = '0;
        ent_row.status    = ST_ROW;
        ent_row.row_slot  = 4'(idx_reg);
        ent_row.row_first = rd_data.first;
        ent_row.row_final = 8'(ent_end - SUM_W'(1));
        ent_row.row_units = rd_data.units;
        ent_row.last_row  = (idx_reg + CW'(1) == count_reg);

        gap_row           = '0;
        gap_row.status    = ST_ROW;
        gap_row.row_first = gpos_reg[7:0];
        gap_row.row_final = rd_data.first - 8'd1;
        gap_row.row_units = 9'(SUM_W'(rd_data.first) - gpos_reg);

        tail_row           = '0;
        tail_row.status    = ST_ROW;
        tail_row.row_first = gpos_reg[7:0];
        tail_row.row_final = 8'(SPACE_END - SUM_W'(1));
        tail_row.row_units = 9'(SPACE_END - gpos_reg);
    end

    // Read address follows the sequencer
    always_comb begin
        if (state_reg == S_MRD) begin
            rd_addr = up_reg ? AW'(idx_reg - CW'(1)) : AW'(idx_reg + CW'(1));
        end else begin
            rd_addr = idx_reg[AW-1:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        up_next        = up_reg;
        fin_next       = fin_reg;
        res_next       = res_reg;
        rv_next        = 1'b0;
        ra_next        = ra_reg;
        cov_next       = cov_reg;
        found_next     = found_reg;
        nxt_next       = nxt_reg;
        pos_next       = pos_reg;
        gpos_next      = gpos_reg;
        pend_next      = pend_reg;
        prow_next      = prow_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg[AW-1:0];
        wr_data        = rd_data;

        // Fold in a scanned entry
        if (rv_reg) begin
            if (!skip_hit) begin
                if (rd_data.first <= cmd_reg.region_first
                        && SUM_W'(cmd_reg.region_first) < ent_end) begin
                    cov_next = 1'b1;
                end
                if (rd_data.first > cmd_reg.region_first && !found_reg) begin
                    found_next = 1'b1;
                    nxt_next   = rd_data.first;
                end
                if (rd_data.first < cmd_reg.region_first) begin
                    pos_next = pos_reg + CW'(1);
                end
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_data;
                    idx_next   = '0;
                    cov_next   = 1'b0;
                    found_next = 1'b0;
                    pos_next   = '0;
                    gpos_next  = '0;
                    pend_next  = 1'b0;
                    res_next   = ST_REJECT;
                    state_next = S_RESP;
                    case (s_data.action)
                        ACT_ADD: begin
                            if (count_reg >= FULL_COUNT) begin
                                res_next = ST_FULL;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        ACT_RESIZE: begin
                            if (SW'(s_data.entry_slot) < SW'(count_reg)) begin
                                state_next = S_SCAN;
                            end
                        end
                        ACT_ERASE: begin
                            if (SW'(s_data.entry_slot) < SW'(count_reg)) begin
                                up_next    = 1'b0;
                                fin_next   = 1'b0;
                                idx_next   = CW'(s_data.entry_slot);
                                rem_next   = count_reg - CW'(1) - CW'(s_data.entry_slot);
                                state_next = (count_reg - CW'(1) == CW'(s_data.entry_slot))
                                           ? S_FIN : S_MRD;
                            end
                        end
                        ACT_GAPS: begin
                            state_next = (count_reg == '0) ? S_GEND : S_GRD;
                        end
                        ACT_ENTRIES: begin
                            if (count_reg == '0) begin
                                res_next = ST_NOROWS;
                            end else begin
                                state_next = S_LRD;
                            end
                        end
                        default: begin
                            res_next = ST_REJECT;
                        end
                    endcase
                end
            end

            // Stream reads of all entries, one per cycle
            S_SCAN: begin
                if (idx_reg < count_reg) begin
                    rv_next  = 1'b1;
                    ra_next  = idx_reg[AW-1:0];
                    idx_next = idx_reg + CW'(1);
                end else if (!rv_reg) begin
                    state_next = S_DEC;
                end
            end

            // Check the request and set up the entry moves
            S_DEC: begin
                fin_next = 1'b1;
                if (bad) begin
                    res_next   = ST_REJECT;
                    state_next = S_RESP;
                end else if (cmd_reg.action == ACT_ADD) begin
                    up_next    = 1'b1;
                    idx_next   = count_reg;
                    rem_next   = count_reg - pos_reg;
                    state_next = (count_reg == pos_reg) ? S_FIN : S_MRD;
                end else if (SW'(pos_reg) < SW'(cmd_reg.entry_slot)) begin
                    up_next    = 1'b1;
                    idx_next   = CW'(cmd_reg.entry_slot);
                    rem_next   = CW'(cmd_reg.entry_slot) - pos_reg;
                    state_next = S_MRD;
                end else begin
                    up_next    = 1'b0;
                    idx_next   = CW'(cmd_reg.entry_slot);
                    rem_next   = pos_reg - CW'(cmd_reg.entry_slot);
                    state_next = (SW'(pos_reg) == SW'(cmd_reg.entry_slot)) ? S_FIN : S_MRD;
                end
            end

            S_MRD: begin
                state_next = S_MWR;
            end

            // Write the neighbor into the current slot and advance
            S_MWR: begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[AW-1:0];
                wr_data  = rd_data;
                idx_next = up_reg ? idx_reg - CW'(1) : idx_reg + CW'(1);
                rem_next = rem_reg - CW'(1);
                state_next = (rem_reg == CW'(1)) ? S_FIN : S_MRD;
            end

            // Place the new entry, if any, and update the count on add or erase
            S_FIN: begin
                if (fin_reg) begin
                    wr_en         = 1'b1;
                    wr_addr       = pos_reg[AW-1:0];
                    wr_data.first = cmd_reg.region_first;
                    wr_data.units = cmd_reg.region_units;
                end
                if (cmd_reg.action == ACT_ADD) begin
                    count_next = count_reg + CW'(1);
                end else if (cmd_reg.action == ACT_ERASE) begin
                    count_next = count_reg - CW'(1);
                end
                res_next   = ST_DONE;
                state_next = S_RESP;
            end

            S_RESP: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_next        = none_row;
                    out_next.status = res_reg;
                    state_next      = S_IDLE;
                end
            end

            S_LRD: begin
                state_next = S_LOUT;
            end

            // Emit one entry row
            S_LOUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next       = ent_row;
                    if (ent_row.last_row) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_LRD;
                    end
                end
            end

            S_GRD: begin
                state_next = S_GOUT;
            end

            // Hold back one gap so the final one can carry the last marker
            S_GOUT: begin
                if (!(SUM_W'(rd_data.first) > gpos_reg && pend_reg && !out_free)) begin
                    if (SUM_W'(rd_data.first) > gpos_reg) begin
                        if (pend_reg) begin
                            out_valid_next = 1'b1;
                            out_next       = prow_reg;
                        end
                        pend_next = 1'b1;
                        prow_next = gap_row;
                    end
                    gpos_next = ent_end;
                    idx_next  = idx_reg + CW'(1);
                    state_next = (idx_reg + CW'(1) == count_reg) ? S_GEND : S_GRD;
                end
            end

            // Tail gap, then flush the held gap as the last row, or report no rows
            S_GEND: begin
                if (gpos_reg < SPACE_END) begin
                    if (!pend_reg || out_free) begin
                        if (pend_reg) begin
                            out_valid_next = 1'b1;
                            out_next       = prow_reg;
                        end
                        pend_next = 1'b1;
                        prow_next = tail_row;
                        gpos_next = SPACE_END;
                    end
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    if (pend_reg) begin
                        out_next          = prow_reg;
                        out_next.last_row = 1'b1;
                    end else begin
                        out_next        = none_row;
                        out_next.status = ST_NOROWS;
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rv_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            rv_reg        <= rv_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        rem_reg   <= rem_next;
        up_reg    <= up_next;
        fin_reg   <= fin_next;
        res_reg   <= res_next;
        ra_reg    <= ra_next;
        cov_reg   <= cov_next;
        found_reg <= found_next;
        nxt_reg   <= nxt_next;
        pos_reg   <= pos_next;
        gpos_reg  <= gpos_next;
        pend_reg  <= pend_next;
        prow_reg  <= prow_next;
        out_reg   <= out_next;
    end

endmodule
